>>> sv/gbi_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the bilinear grid interpolator
// no dependencies
package gbi_pkg;

  localparam int GRID_CELLS  = 65536;
  localparam int GRID_ADDR_W = $clog2(GRID_CELLS);
  localparam int POS_W       = 24;
  localparam int SPACE_W     = 16;
  localparam int TIME_W      = 32;
  localparam int BORDER_W    = 4;
  localparam int IDX_W       = POS_W + 1;
  localparam int PROD_W      = IDX_W + SPACE_W;
  localparam int LIN_W       = PROD_W + 1;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    REG_CELL_WIDTH_X  = 2'd0,
    REG_CELL_HEIGHT_Z = 2'd1,
    REG_PADDED_DEPTH  = 2'd2,
    REG_BORDER_CELLS  = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ADDR,
    B_CHECK,
    B_READ,
    B_DRAIN,
    B_DIV,
    B_OUT
  } back_state_e;

  typedef struct packed {
    logic [SPACE_W-1:0]  dx;
    logic [SPACE_W-1:0]  dz;
    logic [SPACE_W-1:0]  depth;
    logic [BORDER_W-1:0] border;
  } cfg_t;

  // one classified item on its way from front to back
  typedef struct packed {
    kind_e              kind;
    logic [15:0]        addr;
    logic [TIME_W-1:0]  cell_time;
    logic [POS_W-1:0]   ix;
    logic [SPACE_W-1:0] rx;
    logic [POS_W-1:0]   iz;
    logic [SPACE_W-1:0] rz;
    logic               last;
  } item_t;

  // spacing with zero taken as one
  function automatic logic [SPACE_W-1:0] eff_space(input logic [SPACE_W-1:0] s);
    eff_space = (s == '0) ? SPACE_W'(1) : s;
  endfunction

endpackage

>>> sv/gbi_front.sv
`timescale 1ns / 1ps
// front end: accepts transactions and finds cell index and offset of queries
// depends on gbi_pkg
module gbi_front import gbi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  kind_e              kind_i,
  input  logic [15:0]        addr_i,
  input  logic [TIME_W-1:0]  time_i,
  input  logic [POS_W-1:0]   px_i,
  input  logic [POS_W-1:0]   pz_i,
  input  logic               last_i,
  output logic               push_o,
  output item_t              item_o,
  input  logic               full_i
);

  localparam int CNT_W = $clog2(POS_W + 1);

  logic               busy_q, div_q;
  logic [CNT_W-1:0]   cnt_q;
  kind_e              kind_q;
  logic [15:0]        addr_q;
  logic [TIME_W-1:0]  time_q;
  logic               last_q;
  logic [POS_W-1:0]   nx_q, nz_q;
  logic [SPACE_W-1:0] remx_q, remz_q;
  logic [SPACE_W-1:0] dxe, dze;
  logic [SPACE_W:0]   tx, tz;
  logic               gex, gez, accept;

  assign dxe = eff_space(cfg_i.dx);
  assign dze = eff_space(cfg_i.dz);

  // one quotient bit per cycle for both axes
  assign tx  = {remx_q, nx_q[POS_W-1]};
  assign tz  = {remz_q, nz_q[POS_W-1]};
  assign gex = tx >= {1'b0, dxe};
  assign gez = tz >= {1'b0, dze};

  assign push_o     = busy_q && !div_q && !full_i;
  assign in_ready_o = !busy_q || push_o;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      div_q  <= 1'b0;
      cnt_q  <= '0;
    end else if (accept) begin
      busy_q <= 1'b1;
      div_q  <= (kind_i == KIND_QUERY);
      cnt_q  <= CNT_W'(POS_W);
    end else begin
      if (push_o) busy_q <= 1'b0;
      if (div_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) div_q <= 1'b0;
      end
    end
  end

  // payload and divider datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      addr_q <= addr_i;
      time_q <= time_i;
      last_q <= last_i;
      nx_q   <= px_i;
      nz_q   <= pz_i;
      remx_q <= '0;
      remz_q <= '0;
    end else if (div_q) begin
      nx_q   <= {nx_q[POS_W-2:0], gex};
      nz_q   <= {nz_q[POS_W-2:0], gez};
      remx_q <= gex ? SPACE_W'(tx - {1'b0, dxe}) : tx[SPACE_W-1:0];
      remz_q <= gez ? SPACE_W'(tz - {1'b0, dze}) : tz[SPACE_W-1:0];
    end
  end

  always_comb begin
    item_o.kind      = kind_q;
    item_o.addr      = addr_q;
    item_o.cell_time = time_q;
    item_o.ix        = nx_q;
    item_o.rx        = remx_q;
    item_o.iz        = nz_q;
    item_o.rz        = remz_q;
    item_o.last      = last_q;
  end

endmodule

>>> sv/gbi_queue.sv
`timescale 1ns / 1ps
// two-entry queue between front and back
// depends on gbi_pkg
module gbi_queue import gbi_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign item_o  = mem_q[rptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= item_i;
  end

endmodule

>>> sv/gbi_back.sv
`timescale 1ns / 1ps
// back end: grid memory, corner reads, weighted sum and final division
// depends on gbi_pkg
module gbi_back import gbi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              valid_i,
  input  item_t             item_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [TIME_W-1:0] out_time_o,
  output logic              out_flag_o,
  output logic              out_last_o
);

  localparam int ACC_W = 2 * TIME_W;
  localparam int DC_W  = $clog2(TIME_W + 1);

  logic [TIME_W-1:0] grid_q [GRID_CELLS];

  back_state_e state_q, state_d;
  item_t              it_q;
  logic [IDX_W-1:0]   zlo_q;
  logic [PROD_W-1:0]  prod_q;
  logic [TIME_W-1:0]  den_q;
  logic [SPACE_W-1:0] wxl_q, wzl_q;
  logic [GRID_ADDR_W-1:0] base_q, raddr;
  logic [1:0]         rc_q;
  logic [TIME_W-1:0]  rdata_q, w_q;
  logic               v1_q, v2_q;
  logic [ACC_W-1:0]   p_q, acc_q;
  logic [TIME_W-1:0]  rem_q, qsh_q;
  logic [DC_W-1:0]    dc_q;
  logic [TIME_W-1:0]  res_time_q;
  logic               res_flag_q, res_last_q;
  logic               ov_q, of_q, ol_q;
  logic [TIME_W-1:0]  ot_q;
  logic [SPACE_W-1:0] dxe, dze, wx, wz;
  logic [LIN_W-1:0]   a11, a22;
  logic [IDX_W:0]     zhi;
  logic               flag, load_out, wr_en;
  logic [TIME_W:0]    dt;
  logic               dge;

  assign dxe = eff_space(cfg_i.dx);
  assign dze = eff_space(cfg_i.dz);

  // corner addresses and range check
  assign a11  = LIN_W'(zlo_q) + LIN_W'(prod_q);
  assign a22  = a11 + LIN_W'(cfg_i.depth) + LIN_W'(1);
  assign zhi  = {1'b0, zlo_q} + (IDX_W + 1)'(1);
  assign flag = (zhi >= (IDX_W + 1)'(cfg_i.depth)) || (a22 >= LIN_W'(GRID_CELLS));

  // corner order: low/low, high x, high z, high/high
  always_comb begin
    case (rc_q)
      2'd0:    raddr = base_q;
      2'd1:    raddr = base_q + GRID_ADDR_W'(cfg_i.depth);
      2'd2:    raddr = base_q + GRID_ADDR_W'(1);
      default: raddr = base_q + GRID_ADDR_W'(cfg_i.depth) + GRID_ADDR_W'(1);
    endcase
    wx = rc_q[0] ? it_q.rx : wxl_q;
    wz = rc_q[1] ? it_q.rz : wzl_q;
  end

  // restoring division step
  assign dt  = {rem_q, qsh_q[TIME_W-1]};
  assign dge = dt >= {1'b0, den_q};

  assign load_out = (state_q == B_OUT) && (!ov_q || out_ready_i);
  assign pop_o    = (state_q == B_IDLE) && valid_i;
  assign wr_en    = pop_o && (item_i.kind == KIND_WRITE)
                    && (32'(item_i.addr) < GRID_CELLS);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE:  if (pop_o && item_i.kind == KIND_QUERY) state_d = B_ADDR;
      B_ADDR:  state_d = B_CHECK;
      B_CHECK: state_d = flag ? B_OUT : B_READ;
      B_READ:  if (rc_q == 2'd3) state_d = B_DRAIN;
      B_DRAIN: if (!v1_q && !v2_q) state_d = B_DIV;
      B_DIV:   if (dc_q == DC_W'(1)) state_d = B_OUT;
      B_OUT:   if (load_out) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= state_q == B_READ;
      v2_q    <= v1_q;
      if (load_out)         ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  // grid memory
  always_ff @(posedge clk_i) begin
    if (wr_en) grid_q[item_i.addr[GRID_ADDR_W-1:0]] <= item_i.cell_time;
    rdata_q <= grid_q[raddr];
  end

  // query datapath
  always_ff @(posedge clk_i) begin
    if (pop_o) it_q <= item_i;
    if (state_q == B_ADDR) begin
      zlo_q  <= IDX_W'(it_q.iz) + IDX_W'(cfg_i.border);
      prod_q <= (IDX_W'(it_q.ix) + IDX_W'(cfg_i.border)) * PROD_W'(cfg_i.depth);
      den_q  <= TIME_W'(dxe) * TIME_W'(dze);
      wxl_q  <= dxe - it_q.rx;
      wzl_q  <= dze - it_q.rz;
    end
    if (state_q == B_CHECK) begin
      base_q     <= a11[GRID_ADDR_W-1:0];
      rc_q       <= '0;
      acc_q      <= '0;
      res_time_q <= '0;
      res_flag_q <= flag;
      res_last_q <= it_q.last;
    end
    if (state_q == B_READ) begin
      rc_q <= rc_q + 2'd1;
      w_q  <= TIME_W'(wx) * TIME_W'(wz);
    end
    if (v1_q) p_q <= ACC_W'(rdata_q) * ACC_W'(w_q);
    if (v2_q) acc_q <= acc_q + p_q;
    if (state_q == B_DRAIN) begin
      rem_q <= acc_q[ACC_W-1:TIME_W];
      qsh_q <= acc_q[TIME_W-1:0];
      dc_q  <= DC_W'(TIME_W);
    end
    if (state_q == B_DIV) begin
      rem_q <= dge ? TIME_W'(dt - {1'b0, den_q}) : dt[TIME_W-1:0];
      qsh_q <= {qsh_q[TIME_W-2:0], dge};
      dc_q  <= dc_q - 1'b1;
      if (dc_q == DC_W'(1)) res_time_q <= {qsh_q[TIME_W-2:0], dge};
    end
    if (load_out) begin
      ot_q <= res_time_q;
      of_q <= res_flag_q;
      ol_q <= res_last_q;
    end
  end

  assign out_valid_o = ov_q;
  assign out_time_o  = ot_q;
  assign out_flag_o  = of_q;
  assign out_last_o  = ol_q;

endmodule

>>> sv/grid_bilinear_interpolator.sv
`timescale 1ns / 1ps
// top level: configuration registers, front end, queue and back end
// depends on gbi_pkg, gbi_front, gbi_queue, gbi_back
//
// A load transaction (tuser 0) writes one 32-bit grid cell and gives no result; the
// front end passes it on in the cycle after acceptance unless the queue is full, so
// loads stream at one per cycle while the queue has room, and the back end writes the
// cell at the edge where it leaves the queue. A query transaction (tuser 1) passes
// through a one-bit-per-cycle divider in the front end that finds cell index and offset
// for x and z, and then through the back end: queue pop, address set-up, range check,
// four reads through the single grid memory port, multiply-accumulate drain, a
// bit-serial divide by dx*dz and the output load. Front and back overlap through a
// two-entry queue; the back end pops no new item until its current query has left.
// A query with a corner outside the grid goes from the range check straight to the
// output load. A stalled result holds the back end, then the queue, then the input.
module grid_bilinear_interpolator import gbi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cell_address[15:0], cell_time[47:16], receiver_x[71:48], receiver_z[95:72]
  input  logic [95:0] s_axis_tdata,
  // kind
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // travel_time[31:0]
  output logic [31:0] m_axis_tdata,
  // out_of_grid
  output logic        m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t     cfg_q;
  reg_idx_e ridx;
  logic     front_push, q_full, q_valid, back_pop;
  item_t    front_item, q_item;

  assign pready = 1'b1;
  assign ridx   = reg_idx_e'(paddr[3:2]);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dx     <= 16'd256;
      cfg_q.dz     <= 16'd256;
      cfg_q.depth  <= 16'd256;
      cfg_q.border <= 4'd1;
    end else if (psel && penable && pwrite && pready) begin
      unique case (ridx)
        REG_CELL_WIDTH_X:  cfg_q.dx     <= pwdata[15:0];
        REG_CELL_HEIGHT_Z: cfg_q.dz     <= pwdata[15:0];
        REG_PADDED_DEPTH:  cfg_q.depth  <= pwdata[15:0];
        REG_BORDER_CELLS:  cfg_q.border <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    unique case (ridx)
      REG_CELL_WIDTH_X:  prdata = {16'd0, cfg_q.dx};
      REG_CELL_HEIGHT_Z: prdata = {16'd0, cfg_q.dz};
      REG_PADDED_DEPTH:  prdata = {16'd0, cfg_q.depth};
      REG_BORDER_CELLS:  prdata = {28'd0, cfg_q.border};
      default:           prdata = '0;
    endcase
  end

  gbi_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .kind_i     (kind_e'(s_axis_tuser)),
    .addr_i     (s_axis_tdata[15:0]),
    .time_i     (s_axis_tdata[47:16]),
    .px_i       (s_axis_tdata[71:48]),
    .pz_i       (s_axis_tdata[95:72]),
    .last_i     (s_axis_tlast),
    .push_o     (front_push),
    .item_o     (front_item),
    .full_i     (q_full)
  );

  gbi_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (back_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  gbi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .valid_i     (q_valid),
    .item_i      (q_item),
    .pop_o       (back_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_time_o  (m_axis_tdata),
    .out_flag_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

>>> sv/gbi_checker.sv
`timescale 1ns / 1ps
// port-level checks of the interpolator, bound to the top level
// depends on grid_bilinear_interpolator
module gbi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast,
  input logic        pready
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // a flagged result carries zero time
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'd0)
    else $error("out of grid result with non-zero time");

  // no result, input ready and no wait state right after reset release
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid && s_axis_tready && pready)
    else $error("result or wait state right after reset");

endmodule

bind grid_bilinear_interpolator gbi_checker u_gbi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast),
  .pready        (pready)
);
